### design/sctp_pkg.sv
// ---------------------------------------------------------------------------
// sctp_pkg : shared types and constants for the sound cpu timer/port block
// word formats, command codes, address map and timer widths
// ---------------------------------------------------------------------------
package sctp_pkg;

   // timer geometry
   localparam int NUM_TIMERS     = 3;
   localparam int NUM_PORTS      = 4;
   localparam int PRESCALE_W     = 7;
   localparam int DIVIDER_W      = 8;
   localparam int OUTPUT_W       = 4;

   // default prescaler periods
   localparam int SLOW_PERIOD_DEF = 128;
   localparam int FAST_PERIOD_DEF = 16;

   // command codes
   localparam logic [2:0] CMD_TICK      = 3'd0;
   localparam logic [2:0] CMD_INT_READ  = 3'd1;
   localparam logic [2:0] CMD_INT_WRITE = 3'd2;
   localparam logic [2:0] CMD_EXT_READ  = 3'd3;
   localparam logic [2:0] CMD_EXT_WRITE = 3'd4;

   // address map
   localparam logic [15:0] EXT_PORT_BASE    = 16'h2140;
   localparam logic [15:0] INT_CONTROL      = 16'h00F1;
   localparam logic [15:0] INT_PORT_BASE    = 16'h00F4;
   localparam logic [15:0] INT_PORT_LAST    = 16'h00F7;
   localparam logic [15:0] INT_TARGET_BASE  = 16'h00FA;
   localparam logic [15:0] INT_COUNTER_BASE = 16'h00FD;

   // control register bits
   localparam int CTRL_CLR_LOW_BIT  = 4;
   localparam int CTRL_CLR_HIGH_BIT = 5;

   // request word
   typedef struct packed {
      logic [2:0]  cmd;
      logic [15:0] address;
      logic [7:0]  write_data;
   } req_word_type;

   // response word
   typedef struct packed {
      logic [7:0] read_data;
      logic       to_memory;
      logic       decoded;
   } rsp_word_type;

endpackage

### design/sound_cpu_timer_port_block_unit.sv
// ---------------------------------------------------------------------------
// sound_cpu_timer_port_block_unit : timers and mailbox ports of a sound cpu
// three prescaled timers with 4-bit output counters, four ports each way
// ---------------------------------------------------------------------------
// the response word lands in the output register in the cycle after the request is accepted
// throughput: one word per cycle unless the far side stalls; timer and port state update in the accept cycle
// the request side stalls only while a response waits and the far side stalls
// reset (synchronous, active high) clears all timers, targets and ports
module sound_cpu_timer_port_block_unit #(
   parameter int SLOW_PERIOD = sctp_pkg::SLOW_PERIOD_DEF,
   parameter int FAST_PERIOD = sctp_pkg::FAST_PERIOD_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  sctp_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sctp_pkg::rsp_word_type rsp_data
);

   localparam int PW = sctp_pkg::PRESCALE_W;
   localparam int DW = sctp_pkg::DIVIDER_W;
   localparam int OW = sctp_pkg::OUTPUT_W;
   localparam int NT = sctp_pkg::NUM_TIMERS;
   localparam int NP = sctp_pkg::NUM_PORTS;

   localparam logic [PW-1:0] SLOW_RELOAD = PW'(SLOW_PERIOD - 1);
   localparam logic [PW-1:0] FAST_RELOAD = PW'(FAST_PERIOD - 1);

   // architectural state
   logic [PW-1:0] prescale_ff [NT];
   logic [PW-1:0] prescale_in [NT];
   logic [DW-1:0] divider_ff  [NT];
   logic [DW-1:0] divider_in  [NT];
   logic [OW-1:0] counter_ff  [NT];
   logic [OW-1:0] counter_in  [NT];
   logic [NT-1:0] enable_ff;
   logic [NT-1:0] enable_in;
   logic [DW-1:0] target_ff   [NT];
   logic [DW-1:0] target_in   [NT];
   logic [7:0]    to_sound_ff [NP];
   logic [7:0]    to_sound_in [NP];
   logic [7:0]    to_main_ff  [NP];
   logic [7:0]    to_main_in  [NP];

   // output register
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   sctp_pkg::rsp_word_type rsp_data_ff;
   sctp_pkg::rsp_word_type rsp_data_in;

   logic        accept;
   logic [15:0] port_off;
   logic [15:0] target_off;
   logic [15:0] counter_off;
   logic [15:0] ext_off;
   logic        int_port_hit;
   logic        target_hit;
   logic        counter_hit;
   logic        ext_port_hit;
   logic [DW-1:0] div_inc [NT];

   // handshake
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // address decode
   assign port_off     = req_data.address - sctp_pkg::INT_PORT_BASE;
   assign target_off   = req_data.address - sctp_pkg::INT_TARGET_BASE;
   assign counter_off  = req_data.address - sctp_pkg::INT_COUNTER_BASE;
   assign ext_off      = req_data.address - sctp_pkg::EXT_PORT_BASE;
   assign int_port_hit = (req_data.address >= sctp_pkg::INT_PORT_BASE) &&
                         (req_data.address <= sctp_pkg::INT_PORT_LAST);
   assign target_hit   = (target_off < 16'd3);
   assign counter_hit  = (counter_off < 16'd3);
   assign ext_port_hit = (ext_off < 16'd4);

   // next state and response
   always_comb begin
      prescale_in  = prescale_ff;
      divider_in   = divider_ff;
      counter_in   = counter_ff;
      enable_in    = enable_ff;
      target_in    = target_ff;
      to_sound_in  = to_sound_ff;
      to_main_in   = to_main_ff;
      rsp_data_in  = '0;
      for (int t = 0; t < NT; t++) begin
         div_inc[t] = divider_ff[t] + DW'(1);
      end

      case (req_data.cmd)
         sctp_pkg::CMD_TICK: begin
            for (int t = 0; t < NT; t++) begin
               if (prescale_ff[t] == '0) begin
                  prescale_in[t] = (t == NT - 1) ? FAST_RELOAD : SLOW_RELOAD;
                  if (enable_ff[t]) begin
                     if (div_inc[t] == target_ff[t]) begin
                        divider_in[t] = '0;
                        counter_in[t] = counter_ff[t] + OW'(1);
                     end else begin
                        divider_in[t] = div_inc[t];
                     end
                  end
               end else begin
                  prescale_in[t] = prescale_ff[t] - PW'(1);
               end
            end
         end
         sctp_pkg::CMD_INT_READ: begin
            if (int_port_hit) begin
               rsp_data_in.read_data = to_sound_ff[port_off[1:0]];
               rsp_data_in.decoded   = 1'b1;
            end else if (counter_hit) begin
               rsp_data_in.read_data = 8'(counter_ff[counter_off[1:0]]);
               rsp_data_in.decoded   = 1'b1;
               counter_in[counter_off[1:0]] = '0;
            end else begin
               rsp_data_in.to_memory = 1'b1;
            end
         end
         sctp_pkg::CMD_INT_WRITE: begin
            if (int_port_hit) begin
               to_main_in[port_off[1:0]] = req_data.write_data;
               rsp_data_in.decoded       = 1'b1;
            end else if (req_data.address == sctp_pkg::INT_CONTROL) begin
               // enables, with a rising enable restarting its timer
               for (int t = 0; t < NT; t++) begin
                  if (!enable_ff[t] && req_data.write_data[t]) begin
                     divider_in[t] = '0;
                     counter_in[t] = '0;
                  end
               end
               enable_in = req_data.write_data[NT-1:0];
               // incoming port pair clears
               if (req_data.write_data[sctp_pkg::CTRL_CLR_LOW_BIT]) begin
                  to_sound_in[0] = '0;
                  to_sound_in[1] = '0;
               end
               if (req_data.write_data[sctp_pkg::CTRL_CLR_HIGH_BIT]) begin
                  to_sound_in[2] = '0;
                  to_sound_in[3] = '0;
               end
               rsp_data_in.decoded = 1'b1;
            end else if (target_hit) begin
               target_in[target_off[1:0]] = req_data.write_data;
               rsp_data_in.decoded        = 1'b1;
            end else begin
               rsp_data_in.to_memory = 1'b1;
            end
         end
         sctp_pkg::CMD_EXT_READ: begin
            if (ext_port_hit) begin
               rsp_data_in.read_data = to_main_ff[ext_off[1:0]];
               rsp_data_in.decoded   = 1'b1;
            end
         end
         sctp_pkg::CMD_EXT_WRITE: begin
            if (ext_port_hit) begin
               to_sound_in[ext_off[1:0]] = req_data.write_data;
               rsp_data_in.decoded       = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // output valid
   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < NT; t++) begin
            prescale_ff[t] <= '0;
            divider_ff[t]  <= '0;
            counter_ff[t]  <= '0;
            target_ff[t]   <= '0;
         end
         for (int p = 0; p < NP; p++) begin
            to_sound_ff[p] <= '0;
            to_main_ff[p]  <= '0;
         end
         enable_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            prescale_ff <= prescale_in;
            divider_ff  <= divider_in;
            counter_ff  <= counter_in;
            target_ff   <= target_in;
            to_sound_ff <= to_sound_in;
            to_main_ff  <= to_main_in;
            enable_ff   <= enable_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
